FILE: rtl/cron_schedule_text_parser_defines.svh
// Assertion macros for the cron schedule parser.
`ifndef CRON_SCHEDULE_TEXT_PARSER_DEFINES_SVH
`define CRON_SCHEDULE_TEXT_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define CSP_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define CSP_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define CSP_ASSERT_IMPL(label, clk, rst_n, a, c)
`define CSP_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/csp_pkg.sv
// Types, codes and tables shared by the cron schedule parser.
package csp_pkg;
  localparam int NumW = 7;
  localparam logic [NumW-1:0] NumSat = 7'd127;

  localparam logic [3:0] PH_BETWEEN = 4'd0;
  localparam logic [3:0] PH_ITEM    = 4'd1;
  localparam logic [3:0] PH_STAR    = 4'd2;
  localparam logic [3:0] PH_NUM_A   = 4'd3;
  localparam logic [3:0] PH_B_START = 4'd4;
  localparam logic [3:0] PH_NUM_B   = 4'd5;
  localparam logic [3:0] PH_S_START = 4'd6;
  localparam logic [3:0] PH_NUM_S   = 4'd7;
  localparam logic [3:0] PH_JUNK    = 4'd8;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FEW    = 3'd1;
  localparam logic [2:0] ST_EXTRA  = 3'd2;
  localparam logic [2:0] ST_SYNTAX = 3'd3;
  localparam logic [2:0] ST_ZSTEP  = 3'd4;
  localparam logic [2:0] ST_RANGE  = 3'd5;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [59:0] minute_mask;
    logic [23:0] hour_mask;
    logic [31:0] day_mask;
    logic [12:0] month_mask;
    logic [6:0]  weekday_mask;
    logic [2:0]  status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take_char;  // run one character through the parser
    logic fill_step;  // set one mask bit of the pending item
    logic finish;     // end of text: close the current field
    logic form;       // all fills done: load the result register
  } csp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fill_busy;  // an item expansion is pending
  } csp_sts_t;

  function automatic logic [7:0] alias_char(input logic [2:0] k, input logic [3:0] p);
    logic [63:0] s;
    begin
      unique case (k)
        3'd0:    s = "@hourly";
        3'd1:    s = "@daily";
        3'd2:    s = "@weekly";
        3'd3:    s = "@monthly";
        default: s = "@yearly";
      endcase
      alias_char = 8'h00;
      case (k)
        3'd0, 3'd2, 3'd4: if (p < 4'd7) alias_char = s[8*(6-p[2:0]) +: 8];
        3'd1:             if (p < 4'd6) alias_char = s[8*(5-p[2:0]) +: 8];
        default:          if (p < 4'd8) alias_char = s[8*(7-p[2:0]) +: 8];
      endcase
    end
  endfunction

  function automatic logic [3:0] alias_len(input logic [2:0] k);
    case (k)
      3'd1:    alias_len = 4'd6;
      3'd3:    alias_len = 4'd8;
      default: alias_len = 4'd7;
    endcase
  endfunction

  function automatic logic [NumW-1:0] field_lo(input logic [2:0] fi);
    field_lo = (fi == 3'd3 || fi == 3'd4) ? 7'd1 : 7'd0;
  endfunction

  function automatic logic [NumW-1:0] field_hi(input logic [2:0] fi);
    case (fi)
      3'd1:    field_hi = 7'd59;
      3'd2:    field_hi = 7'd23;
      3'd3:    field_hi = 7'd31;
      3'd4:    field_hi = 7'd12;
      3'd5:    field_hi = 7'd6;
      default: field_hi = 7'd0;
    endcase
  endfunction
endpackage

FILE: rtl/cron_schedule_text_parser.sv
// A character is taken in S_IDLE; S_FILL then sets each mask bit of the
// item it closes (up to 60) before the next is taken; on the last character S_FIN
// closes the current field, and S_FORM finishes that fill and loads the result.
// Throughput: one request at a time; the bit fill unit sets the rate.
// Reset: synchronous active-low rst_n returns the parser to between fields,
// masks cleared, all alias candidates live; the same happens after each result.
module cron_schedule_text_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  csp_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output csp_pkg::out_item_t    out_data
);
`include "cron_schedule_text_parser_defines.svh"

  csp_pkg::csp_cmd_t cmd;
  csp_pkg::csp_sts_t sts;
  logic              res_err;

  csp_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_last(in_data.last_char),
    .out_valid, .out_ready, .cmd, .sts
  );

  csp_dpath u_dpath (
    .clk, .rst_n, .in_item(in_data), .cmd, .sts,
    .out_hs(out_valid && out_ready), .out_item(out_data)
  );

  assign res_err = (out_data.status != csp_pkg::ST_OK);

  `CSP_ASSERT_IMPL(a_excl, clk, rst_n, in_ready, !out_valid)
  `CSP_ASSERT_IMPL(a_nofill_out, clk, rst_n, out_valid && out_ready, !sts.fill_busy)
  `CSP_ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && res_err, out_data.minute_mask == '0)
  `CSP_ASSERT_NEXT(a_take_busy, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

FILE: rtl/csp_ctrl.sv
// Sequencer: accepts requests, waits for mask fill, issues the result.
module csp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output csp_pkg::csp_cmd_t   cmd,
  input  csp_pkg::csp_sts_t   sts
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_FORM = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       last_r, last_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_char = 1'b1;
          last_nxt      = in_last;
          state_nxt     = S_FILL;
        end
      end
      S_FILL: begin
        if (sts.fill_busy) cmd.fill_step = 1'b1;
        else state_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        // end of text closes the current field; may start one more fill
        cmd.finish = 1'b1;
        state_nxt  = S_FORM;
      end
      S_FORM: begin
        if (sts.fill_busy) cmd.fill_step = 1'b1;
        else begin
          cmd.form  = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end
endmodule

FILE: rtl/csp_dpath.sv
// Parser state, mask registers, bit fill unit and result formation.
module csp_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csp_pkg::in_item_t    in_item,
  input  csp_pkg::csp_cmd_t    cmd,
  output csp_pkg::csp_sts_t    sts,
  input  logic                 out_hs,
  output csp_pkg::out_item_t   out_item
);
  localparam int W = csp_pkg::NumW;

  logic [3:0]   ph_r, ph_nxt;
  logic [2:0]   fi_r, fi_nxt;
  logic [W-1:0] acc_r, acc_nxt, rs_r, rs_nxt, re_r, re_nxt, stp_r, stp_nxt;
  logic [59:0]  mm_r, mm_nxt;
  logic [23:0]  hm_r, hm_nxt;
  logic [31:0]  dm_r, dm_nxt;
  logic [12:0]  mom_r, mom_nxt;
  logic [6:0]   wm_r, wm_nxt;
  logic [2:0]   err_r, err_nxt;
  logic [4:0]   cand_r, cand_nxt;
  logic [3:0]   pos_r, pos_nxt;
  // pending item expansion
  logic         fb_r, fb_nxt;
  logic [2:0]   ff_r, ff_nxt;
  logic [W:0]   fv_r, fv_nxt;
  logic [W-1:0] fe_r, fe_nxt, fs_r, fs_nxt;
  csp_pkg::out_item_t res_r, res_nxt;

  assign sts.fill_busy = fb_r;
  assign out_item      = res_r;

  logic [7:0] c;
  logic       ws, dig;
  logic [W-1:0] dval;
  logic [10:0] prod;
  assign c    = in_item.char_code;
  assign ws   = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  assign dig  = (c >= 8'd48) && (c <= 8'd57);
  assign dval = {3'b000, c[3:0]};
  assign prod = {4'b0, acc_r} * 11'd10 + {7'b0, c[3:0]};

  always_comb begin
    logic       term, comma, cnt;
    logic [3:0] nxt_ph;
    logic [2:0] fidx;
    logic [W-1:0] lo, hi, a_rs, a_re, a_st;
    logic [W-1:0] acc;
    logic       do_fin, stop;
    logic [2:0] st;
    logic       alias_hit;
    logic [2:0] ak;
    ph_nxt = ph_r; fi_nxt = fi_r; acc_nxt = acc_r; rs_nxt = rs_r; re_nxt = re_r;
    stp_nxt = stp_r; mm_nxt = mm_r; hm_nxt = hm_r; dm_nxt = dm_r; mom_nxt = mom_r;
    wm_nxt = wm_r; err_nxt = err_r; cand_nxt = cand_r; pos_nxt = pos_r;
    fb_nxt = fb_r; ff_nxt = ff_r; fv_nxt = fv_r; fe_nxt = fe_r; fs_nxt = fs_r;
    res_nxt = res_r;
    term = 1'b0; comma = 1'b0; do_fin = 1'b0;
    a_rs = rs_r; a_re = re_r; a_st = stp_r; acc = acc_r;
    alias_hit = 1'b0; ak = 3'd0; st = csp_pkg::ST_OK;
    fidx = fi_r; lo = '0; hi = '0; stop = 1'b0; nxt_ph = ph_r;
    cnt = 1'b0;

    if (cmd.take_char) begin
      for (int k = 0; k < 5; k++)
        if (pos_r >= csp_pkg::alias_len(3'(k)) || csp_pkg::alias_char(3'(k), pos_r) != c)
          cand_nxt[k] = 1'b0;
      if (pos_r != 4'd15) pos_nxt = pos_r + 4'd1;

      if (ph_r == csp_pkg::PH_BETWEEN && ws) begin
        stop = 1'b1;
      end else begin
        if (ph_r == csp_pkg::PH_BETWEEN) begin
          if (fi_r < 3'd6) fidx = fi_r + 3'd1;
          nxt_ph = csp_pkg::PH_ITEM; acc = '0; a_st = 7'd1;
        end
        fi_nxt = fidx;
        if (ws || c == 8'd44) begin
          term = 1'b1; comma = (c == 8'd44);
        end
      end
    end else if (cmd.finish) begin
      term = 1'b1; comma = 1'b0;
    end

    cnt = (fidx >= 3'd1) && (fidx <= 3'd5);
    lo  = csp_pkg::field_lo(fidx);
    hi  = csp_pkg::field_hi(fidx);

    if (cmd.take_char && !stop && !term) begin
      unique case (nxt_ph)
        csp_pkg::PH_ITEM: begin
          if (c == 8'd42) begin a_rs = lo; a_re = hi; nxt_ph = csp_pkg::PH_STAR; end
          else if (dig) begin acc = dval; nxt_ph = csp_pkg::PH_NUM_A; end
          else begin
            if (cnt && err_r == 3'd0) err_nxt = csp_pkg::ST_SYNTAX;
            nxt_ph = csp_pkg::PH_JUNK;
          end
        end
        csp_pkg::PH_STAR: begin
          if (c == 8'd47) nxt_ph = csp_pkg::PH_S_START;
          else begin
            if (cnt && err_r == 3'd0) err_nxt = csp_pkg::ST_SYNTAX;
            nxt_ph = csp_pkg::PH_JUNK;
          end
        end
        csp_pkg::PH_NUM_A, csp_pkg::PH_NUM_B, csp_pkg::PH_NUM_S: begin
          if (dig) acc = (prod > 11'd127) ? csp_pkg::NumSat : prod[W-1:0];
          else if (c == 8'd45 && nxt_ph == csp_pkg::PH_NUM_A) begin
            a_rs = acc_r; acc = '0; nxt_ph = csp_pkg::PH_B_START;
          end else if (c == 8'd47 && nxt_ph == csp_pkg::PH_NUM_A) begin
            a_rs = acc_r; a_re = acc_r; acc = '0; nxt_ph = csp_pkg::PH_S_START;
          end else if (c == 8'd47 && nxt_ph == csp_pkg::PH_NUM_B) begin
            a_re = acc_r; acc = '0; nxt_ph = csp_pkg::PH_S_START;
          end else begin
            if (cnt && err_r == 3'd0) err_nxt = csp_pkg::ST_SYNTAX;
            nxt_ph = csp_pkg::PH_JUNK;
          end
        end
        csp_pkg::PH_B_START: begin
          if (dig) begin acc = dval; nxt_ph = csp_pkg::PH_NUM_B; end
          else begin
            if (cnt && err_r == 3'd0) err_nxt = csp_pkg::ST_SYNTAX;
            nxt_ph = csp_pkg::PH_JUNK;
          end
        end
        csp_pkg::PH_S_START: begin
          if (dig) begin acc = dval; nxt_ph = csp_pkg::PH_NUM_S; end
          else begin
            if (cnt && err_r == 3'd0) err_nxt = csp_pkg::ST_SYNTAX;
            nxt_ph = csp_pkg::PH_JUNK;
          end
        end
        default: nxt_ph = csp_pkg::PH_JUNK;
      endcase
    end

    if (term) begin
      case (nxt_ph)
        csp_pkg::PH_NUM_A: begin a_rs = acc; a_re = acc; do_fin = 1'b1; end
        csp_pkg::PH_NUM_B: begin a_re = acc; do_fin = 1'b1; end
        csp_pkg::PH_NUM_S: begin a_st = acc; do_fin = 1'b1; end
        csp_pkg::PH_STAR:  do_fin = 1'b1;
        csp_pkg::PH_ITEM, csp_pkg::PH_B_START, csp_pkg::PH_S_START: begin
          if (cnt && err_r == 3'd0) err_nxt = csp_pkg::ST_SYNTAX;
          nxt_ph = comma ? csp_pkg::PH_JUNK : csp_pkg::PH_BETWEEN;
        end
        csp_pkg::PH_BETWEEN: ;
        default: nxt_ph = comma ? csp_pkg::PH_JUNK : csp_pkg::PH_BETWEEN;
      endcase
      if (do_fin) begin
        nxt_ph = comma ? csp_pkg::PH_ITEM : csp_pkg::PH_BETWEEN;
        if (cnt) begin
          if (a_st == '0) begin
            if (err_r == 3'd0) err_nxt = csp_pkg::ST_ZSTEP;
          end else if (a_rs < lo || a_re > hi || a_rs > a_re) begin
            if (err_r == 3'd0) err_nxt = csp_pkg::ST_RANGE;
          end else begin
            // hand the item to the fill unit, one bit per cycle
            fb_nxt = 1'b1; ff_nxt = fidx; fv_nxt = {1'b0, a_rs};
            fe_nxt = a_re; fs_nxt = a_st;
          end
        end
        acc = '0; a_st = 7'd1;
      end
    end

    if (cmd.take_char || cmd.finish) begin
      ph_nxt = nxt_ph; acc_nxt = acc; rs_nxt = a_rs; re_nxt = a_re; stp_nxt = a_st;
    end

    if (cmd.fill_step) begin
      unique case (ff_r)
        3'd1:    mm_nxt[fv_r[5:0]]  = 1'b1;
        3'd2:    hm_nxt[fv_r[4:0]]  = 1'b1;
        3'd3:    dm_nxt[fv_r[4:0]]  = 1'b1;
        3'd4:    mom_nxt[fv_r[3:0]] = 1'b1;
        default: wm_nxt[fv_r[2:0]]  = 1'b1;
      endcase
      fv_nxt = fv_r + {1'b0, fs_r};
      if (fv_nxt > {1'b0, fe_r}) fb_nxt = 1'b0;
    end

    // result taken from the settled state once every fill is done
    if (cmd.form) begin
      for (int k = 0; k < 5; k++)
        if (cand_r[k] && pos_r == csp_pkg::alias_len(3'(k))) begin
          alias_hit = 1'b1; ak = 3'(k);
        end
      res_nxt = '0;
      if (alias_hit) begin
        res_nxt.minute_mask  = 60'd1;
        res_nxt.hour_mask    = (ak == 3'd0) ? 24'hFFFFFF : 24'd1;
        res_nxt.day_mask     = (ak >= 3'd3) ? 32'd2 : 32'hFFFFFFFE;
        res_nxt.month_mask   = (ak == 3'd4) ? 13'd2 : 13'h1FFE;
        res_nxt.weekday_mask = (ak == 3'd2) ? 7'd1 : 7'h7F;
        res_nxt.status       = csp_pkg::ST_OK;
      end else begin
        if (fi_r < 3'd5) st = csp_pkg::ST_FEW;
        else if (fi_r > 3'd5) st = csp_pkg::ST_EXTRA;
        else st = err_r;
        res_nxt.status = st;
        if (st == csp_pkg::ST_OK) begin
          res_nxt.minute_mask  = mm_r;
          res_nxt.hour_mask    = hm_r;
          res_nxt.day_mask     = dm_r;
          res_nxt.month_mask   = mom_r;
          res_nxt.weekday_mask = wm_r;
        end
      end
    end

    if (out_hs) begin
      ph_nxt = csp_pkg::PH_BETWEEN; fi_nxt = '0; acc_nxt = '0; rs_nxt = '0; re_nxt = '0;
      stp_nxt = 7'd1; mm_nxt = '0; hm_nxt = '0; dm_nxt = '0; mom_nxt = '0; wm_nxt = '0;
      err_nxt = '0; cand_nxt = 5'h1F; pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= csp_pkg::PH_BETWEEN; fi_r <= '0; acc_r <= '0; rs_r <= '0; re_r <= '0;
      stp_r <= 7'd1; mm_r <= '0; hm_r <= '0; dm_r <= '0; mom_r <= '0; wm_r <= '0;
      err_r <= '0; cand_r <= 5'h1F; pos_r <= '0; fb_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; fi_r <= fi_nxt; acc_r <= acc_nxt; rs_r <= rs_nxt; re_r <= re_nxt;
      stp_r <= stp_nxt; mm_r <= mm_nxt; hm_r <= hm_nxt; dm_r <= dm_nxt; mom_r <= mom_nxt;
      wm_r <= wm_nxt; err_r <= err_nxt; cand_r <= cand_nxt; pos_r <= pos_nxt;
      fb_r <= fb_nxt;
    end
  end

  // fill operands and result register; only read once loaded
  always_ff @(posedge clk) begin
    ff_r <= ff_nxt; fv_r <= fv_nxt; fe_r <= fe_nxt; fs_r <= fs_nxt;
    res_r <= res_nxt;
  end
endmodule
